>>> hdl/cpp_pkg.sv
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types, sizes and helpers for the closest pair of points search.
// ----------------------------------------------------------------------------
package cpp_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 16;

  localparam int FIELD_W    = 16;
  localparam int OUT_DIST_W = 35;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int DIST_W     = 2 * COORD_BITS + 1;

  localparam logic [OUT_DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic   valid;
    point_t a;
    point_t b;
  } dist_req_t;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] sq_sum;
    point_t            a;
    point_t            b;
  } dist_rsp_t;

  function automatic logic [FIELD_W-1:0] to_field(input logic [COORD_BITS-1:0] v);
    return FIELD_W'($signed(v));
  endfunction

  function automatic logic [OUT_DIST_W-1:0] sat_dist(input logic [DIST_W-1:0] d);
    logic [63:0] w;
    w = 64'(d);
    return (w > 64'(DIST_MAX)) ? DIST_MAX : OUT_DIST_W'(w);
  endfunction

endpackage

>>> hdl/cpp_cell.sv
// ----------------------------------------------------------------------------
// cpp_cell
// One ring cell: holds a point, loads a new one or takes its neighbor's.
// ----------------------------------------------------------------------------
module cpp_cell (
  input  logic            clk_i,
  input  logic            load_i,
  input  logic            shift_i,
  input  cpp_pkg::point_t load_pt_i,
  input  cpp_pkg::point_t next_pt_i,
  output cpp_pkg::point_t pt_o
);
  import cpp_pkg::*;

  point_t pt_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pt_q <= load_pt_i;
    end else if (shift_i) begin
      pt_q <= next_pt_i;
    end
  end

  assign pt_o = pt_q;

endmodule

>>> hdl/cpp_dist.sv
// ----------------------------------------------------------------------------
// cpp_dist
// Three-stage squared distance unit: abs difference, square, sum.
// ----------------------------------------------------------------------------
module cpp_dist (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpp_pkg::dist_req_t req_i,
  output cpp_pkg::dist_rsp_t rsp_o,
  output logic               busy_o
);
  import cpp_pkg::*;

  logic                    v1_q, v2_q, v3_q;
  point_t                  a1_q, b1_q, a2_q, b2_q, a3_q, b3_q;
  logic signed [COORD_BITS:0] ddx, ddy;
  logic [COORD_BITS-1:0]   adx_d, ady_d, adx_q, ady_q;
  logic [SQ_W-1:0]         sqx_q, sqy_q;
  logic [DIST_W-1:0]       dist_q;

  always_comb begin
    ddx   = (COORD_BITS+1)'($signed(req_i.a.x)) - (COORD_BITS+1)'($signed(req_i.b.x));
    ddy   = (COORD_BITS+1)'($signed(req_i.a.y)) - (COORD_BITS+1)'($signed(req_i.b.y));
    adx_d = ddx[COORD_BITS] ? COORD_BITS'(-ddx) : COORD_BITS'(ddx);
    ady_d = ddy[COORD_BITS] ? COORD_BITS'(-ddy) : COORD_BITS'(ddy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q  <= adx_d;
    ady_q  <= ady_d;
    a1_q   <= req_i.a;
    b1_q   <= req_i.b;
    sqx_q  <= SQ_W'(adx_q) * SQ_W'(adx_q);
    sqy_q  <= SQ_W'(ady_q) * SQ_W'(ady_q);
    a2_q   <= a1_q;
    b2_q   <= b1_q;
    dist_q <= DIST_W'(sqx_q) + DIST_W'(sqy_q);
    a3_q   <= a2_q;
    b3_q   <= b2_q;
  end

  assign rsp_o.valid  = v3_q;
  assign rsp_o.sq_sum = dist_q;
  assign rsp_o.a      = a3_q;
  assign rsp_o.b      = b3_q;
  assign busy_o       = v1_q | v2_q | v3_q;

endmodule

>>> hdl/closest_pair_of_points.sv
// ----------------------------------------------------------------------------
// closest_pair_of_points
// Loads a point set into a ring of cells, then rotates the ring past a
// captured pivot to find the pair with the smallest squared distance.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+---------------------------------
//  in       | in_valid_i   | in_stall_o   | point_x_i point_y_i last_point_i
//  out      | out_valid_o  | out_stall_i  | first_x/y second_x/y min_sq_dist
//           |              |              | pair_valid overflowed
//
//  Points load one per cycle while input is not stalled. After the last point
//  of a set with two or more stored points, the search gives each pivot one full
//  ring rotation plus one step, then waits for the distance unit to drain; a set
//  with fewer points goes straight to drain. Input is stalled during the search
//  and drain, and a last point is stalled while an earlier result still waits.
//  Reset clears control state; ring contents are undefined until loaded.
// ----------------------------------------------------------------------------
module closest_pair_of_points (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cpp_pkg::FIELD_W-1:0]  point_x_i,
  input  logic signed [cpp_pkg::FIELD_W-1:0]  point_y_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cpp_pkg::FIELD_W-1:0]  first_x_o,
  output logic signed [cpp_pkg::FIELD_W-1:0]  first_y_o,
  output logic signed [cpp_pkg::FIELD_W-1:0]  second_x_o,
  output logic signed [cpp_pkg::FIELD_W-1:0]  second_y_o,
  output logic [cpp_pkg::OUT_DIST_W-1:0]      min_sq_distance_o,
  output logic                                pair_valid_o,
  output logic                                overflowed_o
);
  import cpp_pkg::*;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d, step_q, step_d;
  logic [IDX_W-1:0]        pass_q, pass_d;
  logic                    ovf_q, ovf_d;
  logic [DIST_W-1:0]       best_dist_q, best_dist_d;
  point_t                  best_a_q, best_a_d, best_b_q, best_b_d;
  point_t                  pivot_q, pivot_d;
  logic                    out_valid_q, out_valid_d;
  logic [FIELD_W-1:0]      fx_q, fx_d, fy_q, fy_d, sx_q, sx_d, sy_q, sy_d;
  logic [OUT_DIST_W-1:0]   dist_q, dist_d;
  logic                    pv_q, pv_d, ov_q, ov_d;

  point_t                  ring [MAX_POINTS];
  point_t                  in_pt;
  logic                    in_acc, load_en, shift_en, dist_busy;
  dist_req_t               req;
  dist_rsp_t               rsp;
  logic [CNT_W:0]          j_ext;

  assign in_pt.x = COORD_BITS'($unsigned(point_x_i));
  assign in_pt.y = COORD_BITS'($unsigned(point_y_i));

  for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
    cpp_cell u_cell (
      .clk_i     (clk_i),
      .load_i    (load_en && (count_q == CNT_W'(k))),
      .shift_i   (shift_en),
      .load_pt_i (in_pt),
      .next_pt_i (ring[(k + 1) % MAX_POINTS]),
      .pt_o      (ring[k])
    );
  end

  cpp_dist u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .busy_o (dist_busy)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    pass_d      = pass_q;
    ovf_d       = ovf_q;
    best_dist_d = best_dist_q;
    best_a_d    = best_a_q;
    best_b_d    = best_b_q;
    pivot_d     = pivot_q;
    out_valid_d = out_valid_q && out_stall_i;
    fx_d        = fx_q;
    fy_d        = fy_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    dist_d      = dist_q;
    pv_d        = pv_q;
    ov_d        = ov_q;
    load_en     = 1'b0;
    shift_en    = 1'b0;
    req.valid   = 1'b0;
    req.a       = pivot_q;
    req.b       = ring[0];
    in_stall_o  = (state_q != ST_LOAD) || (last_point_i && out_valid_q);
    in_acc      = in_valid_i && !in_stall_o;
    j_ext       = (CNT_W+1)'(pass_q) + (CNT_W+1)'(step_q);

    if (rsp.valid && (rsp.sq_sum < best_dist_q)) begin
      best_dist_d = rsp.sq_sum;
      best_a_d    = rsp.a;
      best_b_d    = rsp.b;
    end

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (count_q != CNT_W'(MAX_POINTS)) begin
            load_en = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_point_i) begin
            best_dist_d = '1;
            pass_d      = '0;
            step_d      = '0;
            state_d     = (count_d >= CNT_W'(2)) ? ST_SEARCH : ST_DRAIN;
          end
        end
      end
      ST_SEARCH: begin
        shift_en = 1'b1;
        step_d   = step_q + CNT_W'(1);
        if (step_q == '0) begin
          pivot_d = ring[0];
        end else if (j_ext < (CNT_W+1)'(count_q)) begin
          req.valid = 1'b1;
        end
        if ((step_q == CNT_W'(1)) &&
            ((CNT_W+1)'(pass_q) + (CNT_W+1)'(2) == (CNT_W+1)'(count_q))) begin
          state_d = ST_DRAIN;
        end else if (step_q == CNT_W'(MAX_POINTS)) begin
          step_d = '0;
          pass_d = pass_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!dist_busy) begin
          out_valid_d = 1'b1;
          pv_d        = (count_q >= CNT_W'(2));
          ov_d        = ovf_q;
          if (count_q >= CNT_W'(2)) begin
            fx_d   = to_field(best_a_q.x);
            fy_d   = to_field(best_a_q.y);
            sx_d   = to_field(best_b_q.x);
            sy_d   = to_field(best_b_q.y);
            dist_d = sat_dist(best_dist_q);
          end else begin
            fx_d   = '0;
            fy_d   = '0;
            sx_d   = '0;
            sy_d   = '0;
            dist_d = '0;
          end
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      count_q     <= '0;
      step_q      <= '0;
      pass_q      <= '0;
      ovf_q       <= 1'b0;
      best_dist_q <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      ovf_q       <= ovf_d;
      best_dist_q <= best_dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_a_q <= best_a_d;
    best_b_q <= best_b_d;
    pivot_q  <= pivot_d;
    fx_q     <= fx_d;
    fy_q     <= fy_d;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    dist_q   <= dist_d;
    pv_q     <= pv_d;
    ov_q     <= ov_d;
  end

  assign out_valid_o       = out_valid_q;
  assign first_x_o         = fx_q;
  assign first_y_o         = fy_q;
  assign second_x_o        = sx_q;
  assign second_y_o        = sy_q;
  assign min_sq_distance_o = dist_q;
  assign pair_valid_o      = pv_q;
  assign overflowed_o      = ov_q;

endmodule

>>> hdl/closest_pair_of_points_chk.sv
// ----------------------------------------------------------------------------
// closest_pair_of_points_chk
// Port-level checks for the closest pair block, bound to the top level.
// ----------------------------------------------------------------------------
module closest_pair_of_points_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic signed [cpp_pkg::FIELD_W-1:0]  point_x_i,
  input logic signed [cpp_pkg::FIELD_W-1:0]  point_y_i,
  input logic                                last_point_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [cpp_pkg::FIELD_W-1:0]  first_x_o,
  input logic signed [cpp_pkg::FIELD_W-1:0]  first_y_o,
  input logic signed [cpp_pkg::FIELD_W-1:0]  second_x_o,
  input logic signed [cpp_pkg::FIELD_W-1:0]  second_y_o,
  input logic [cpp_pkg::OUT_DIST_W-1:0]      min_sq_distance_o,
  input logic                                pair_valid_o,
  input logic                                overflowed_o
);
  import cpp_pkg::*;

  logic signed [FIELD_W:0] dx, dy;
  logic [FIELD_W-1:0]      ax, ay;
  logic [2*FIELD_W-1:0]    qx, qy;
  logic [OUT_DIST_W-1:0]   sum;

  always_comb begin
    dx  = (FIELD_W+1)'(first_x_o) - (FIELD_W+1)'(second_x_o);
    dy  = (FIELD_W+1)'(first_y_o) - (FIELD_W+1)'(second_y_o);
    ax  = dx[FIELD_W] ? FIELD_W'(-dx) : FIELD_W'(dx);
    ay  = dy[FIELD_W] ? FIELD_W'(-dy) : FIELD_W'(dy);
    qx  = (2*FIELD_W)'(ax) * (2*FIELD_W)'(ax);
    qy  = (2*FIELD_W)'(ay) * (2*FIELD_W)'(ay);
    sum = OUT_DIST_W'(qx) + OUT_DIST_W'(qy);
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(min_sq_distance_o) &&
      $stable(first_x_o) && $stable(second_x_o) && $stable(pair_valid_o) &&
      $stable(overflowed_o))
    else $error("result changed while stalled");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_valid_o |-> first_x_o == '0 && first_y_o == '0 &&
      second_x_o == '0 && second_y_o == '0 && min_sq_distance_o == '0)
    else $error("invalid result carries nonzero fields");

  a_dist_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pair_valid_o |-> (COORD_BITS > FIELD_W) ||
      (min_sq_distance_o == sum))
    else $error("distance does not match returned points");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_point_i |=> in_stall_o)
    else $error("input taken right after last point");

endmodule

bind closest_pair_of_points closest_pair_of_points_chk u_chk (.*);

>>> tb/sv/closest_pair_of_points_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_pair_of_points_test
// Streams point sets into the closest pair search and checks every result
// against an exhaustive all-pairs search of the same points. Both channels
// stall and idle at random, in stretches with and without gaps.
// ----------------------------------------------------------------------------
module closest_pair_of_points_test;
  import cpp_pkg::*;

  localparam int ITEMS = 950;
  localparam int GAP_MAX = 18;
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int REPORT_CAP = 100;

  typedef enum int {
    COORD_SPREAD,
    COORD_CLUSTER,
    COORD_CORNERS,
    COORD_MIXED
  } coord_style_e;

  typedef struct {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic [OUT_DIST_W-1:0]     distance;
    logic                      valid;
    logic                      overflowed;
  } pair_result_t;

  class pair_scoreboard;
    int errors;
    int checked;
    logic signed [FIELD_W-1:0] xs [MAX_POINTS];
    logic signed [FIELD_W-1:0] ys [MAX_POINTS];
    int unsigned count;
    bit dropped;
    pair_result_t expected_q [$];

    function int pending();
      return expected_q.size();
    endfunction

    function longint unsigned sq_distance(int unsigned i, int unsigned j);
      longint dx;
      longint dy;
      dx = longint'(xs[i]) - longint'(xs[j]);
      dy = longint'(ys[i]) - longint'(ys[j]);
      return dx * dx + dy * dy;
    endfunction

    // Exhaustive search; strict less-than keeps the lowest index pair on ties.
    function void note_point(logic signed [FIELD_W-1:0] x, logic signed [FIELD_W-1:0] y,
                             logic is_last);
      pair_result_t want;
      longint unsigned best;
      longint unsigned d;
      int unsigned bi;
      int unsigned bj;
      if (count < MAX_POINTS) begin
        xs[count] = x;
        ys[count] = y;
        count++;
      end else begin
        dropped = 1'b1;
      end
      if (!is_last) return;
      want.first_x = '0;
      want.first_y = '0;
      want.second_x = '0;
      want.second_y = '0;
      want.distance = '0;
      want.valid = (count >= 2);
      want.overflowed = dropped;
      if (count >= 2) begin
        bi = 0;
        bj = 1;
        best = sq_distance(0, 1);
        for (int unsigned i = 0; i < count; i++) begin
          for (int unsigned j = i + 1; j < count; j++) begin
            d = sq_distance(i, j);
            if (d < best) begin
              best = d;
              bi = i;
              bj = j;
            end
          end
        end
        want.first_x = xs[bi];
        want.first_y = ys[bi];
        want.second_x = xs[bj];
        want.second_y = ys[bj];
        want.distance = (best > DIST_MAX) ? DIST_MAX : OUT_DIST_W'(best);
      end
      expected_q.push_back(want);
      count = 0;
      dropped = 1'b0;
    endfunction

    task report(string what, logic signed [63:0] got, logic signed [63:0] want);
      errors++;
      if (errors <= REPORT_CAP)
        $display("mismatch in result %0d, %s: got %0d, expected %0d", checked, what, got,
                 want);
    endtask

    task check_pair(pair_result_t got);
      pair_result_t want;
      if (expected_q.size() == 0) begin
        report("result with no set pending", got.distance, 0);
        return;
      end
      want = expected_q.pop_front();
      if (got.first_x !== want.first_x) report("first_x", got.first_x, want.first_x);
      if (got.first_y !== want.first_y) report("first_y", got.first_y, want.first_y);
      if (got.second_x !== want.second_x) report("second_x", got.second_x, want.second_x);
      if (got.second_y !== want.second_y) report("second_y", got.second_y, want.second_y);
      if (got.distance !== want.distance)
        report("min_sq_distance", got.distance, want.distance);
      if (got.valid !== want.valid) report("pair_valid", got.valid, want.valid);
      if (got.overflowed !== want.overflowed)
        report("overflowed", got.overflowed, want.overflowed);
      checked++;
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [FIELD_W-1:0] point_x_i = '0;
  logic signed [FIELD_W-1:0] point_y_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [FIELD_W-1:0] first_x_o;
  logic signed [FIELD_W-1:0] first_y_o;
  logic signed [FIELD_W-1:0] second_x_o;
  logic signed [FIELD_W-1:0] second_y_o;
  logic [OUT_DIST_W-1:0] min_sq_distance_o;
  logic pair_valid_o;
  logic overflowed_o;

  pair_scoreboard sb = new();
  longint cycles = 0;
  int points_sent = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  closest_pair_of_points i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .point_x_i         (point_x_i),
    .point_y_i         (point_y_i),
    .last_point_i      (last_point_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .first_x_o         (first_x_o),
    .first_y_o         (first_y_o),
    .second_x_o        (second_x_o),
    .second_y_o        (second_y_o),
    .min_sq_distance_o (min_sq_distance_o),
    .pair_valid_o      (pair_valid_o),
    .overflowed_o      (overflowed_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_point(input logic signed [FIELD_W-1:0] x,
                            input logic signed [FIELD_W-1:0] y, input logic is_last);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    last_point_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(x, y, is_last);
    points_sent++;
  endtask

  function automatic logic signed [FIELD_W-1:0] pick_coord(coord_style_e style,
                                                           logic signed [FIELD_W-1:0] base);
    coord_style_e s;
    s = (style == COORD_MIXED) ? coord_style_e'($urandom_range(0, 2)) : style;
    case (s)
      COORD_CLUSTER: begin
        return base + FIELD_W'($urandom_range(0, 16)) - FIELD_W'(8);
      end
      COORD_CORNERS: begin
        case ($urandom_range(0, 6))
          0: return -32768;
          1: return -32767;
          2: return -1;
          3: return 0;
          4: return 1;
          5: return 32766;
          default: return 32767;
        endcase
      end
      default: begin
        return FIELD_W'($urandom);
      end
    endcase
  endfunction

  initial begin
    pair_result_t got;
    int hold;
    wait (rst_ni === 1'b1);
    forever begin
      hold = out_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.first_x = first_x_o;
      got.first_y = first_y_o;
      got.second_x = second_x_o;
      got.second_y = second_y_o;
      got.distance = min_sq_distance_o;
      got.valid = pair_valid_o;
      got.overflowed = overflowed_o;
      sb.check_pair(got);
      if ($urandom_range(0, 7) == 0) out_burst = !out_burst;
    end
  end

  initial begin
    int set_no;
    int size;
    coord_style_e style;
    logic signed [FIELD_W-1:0] base_x;
    logic signed [FIELD_W-1:0] base_y;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // single point sets: no pair
    send_point(5, -7, 1'b1);
    send_point(-32768, 32767, 1'b1);
    // opposite corners: largest distance
    send_point(-32768, -32768, 1'b0);
    send_point(32767, 32767, 1'b1);
    send_point(32767, -32768, 1'b0);
    send_point(-32768, 32767, 1'b1);
    // unit square: four tied pairs, the first one wins
    send_point(0, 0, 1'b0);
    send_point(1, 0, 1'b0);
    send_point(0, 1, 1'b0);
    send_point(1, 1, 1'b1);
    // duplicated points: zero distance twice
    send_point(100, -100, 1'b0);
    send_point(7, 7, 1'b0);
    send_point(100, -100, 1'b0);
    send_point(7, 7, 1'b1);

    for (set_no = 0; points_sent < ITEMS; set_no++) begin
      if (set_no == 3) begin
        size = MAX_POINTS;
      end else if (set_no == 12) begin
        size = MAX_POINTS + 5;
      end else begin
        case ($urandom_range(0, 9))
          0: size = 1;
          1, 2, 3, 4, 5, 6: size = $urandom_range(2, 6);
          7, 8: size = $urandom_range(7, 16);
          default: size = $urandom_range(17, 40);
        endcase
      end
      style = coord_style_e'($urandom_range(0, 3));
      base_x = FIELD_W'($urandom);
      base_y = FIELD_W'($urandom);
      in_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < size; k++)
        send_point(pick_coord(style, base_x), pick_coord(style, base_y), k == size - 1);
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
